@@ rtl/core/timeline_segment_locator_defines.svh @@
// ----------------------------------------------------------------------------
// Timeline segment locator assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TIMELINE_SEGMENT_LOCATOR_DEFINES_SVH
`define TIMELINE_SEGMENT_LOCATOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TSL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after reset has been seen high.
`define TSL_ASSERT_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/tsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeline segment locator package
// Field widths, operation and status codes, controller/datapath handshake types.
// ----------------------------------------------------------------------------
package tsl_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int FRAME_BITS_DEF   = 24;

   localparam int OP_W     = 2;
   localparam int FIELD_W  = 24;
   localparam int INDEX_W  = 6;
   localparam int POS_W    = 31;
   localparam int STATUS_W = 2;
   localparam int LOCAL_W  = 24;
   localparam int TOTAL_W  = 31;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
   localparam logic [OP_W-1:0] OP_TOTAL  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic latch;
      logic append;
      logic rm_sub;
      logic rm_shift;
      logic rm_finish;
      logic loc_step;
      logic load_out;
   } tsl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            abort;
      logic            rd_in_range;
      logic            loc_stop;
      logic            out_free;
   } tsl_stat_type;

endpackage

@@ rtl/core/tsl_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeline segment locator channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface tsl_req_if;
   import tsl_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FIELD_W-1:0] gap_frames;
   logic [FIELD_W-1:0] clip_frames;
   logic [INDEX_W-1:0] entry_index;
   logic [POS_W-1:0]   position;

   modport source (output valid, operation, gap_frames, clip_frames, entry_index,
                   position, input ready);
   modport sink (input valid, operation, gap_frames, clip_frames, entry_index,
                 position, output ready);
endinterface

interface tsl_rsp_if;
   import tsl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                in_clip;
   logic [INDEX_W-1:0]  hit_index;
   logic [LOCAL_W-1:0]  local_frame;
   logic [TOTAL_W-1:0]  total_length;

   modport source (output valid, status, in_clip, hit_index, local_frame, total_length,
                   input ready);
   modport sink (input valid, status, in_clip, hit_index, local_frame, total_length,
                 output ready);
endinterface

@@ rtl/core/tsl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeline segment locator controller
// Sequences append, remove, locate and total over the datapath.
// ----------------------------------------------------------------------------
module tsl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tsl_pkg::tsl_stat_type stat,
   output tsl_pkg::tsl_cmd_type  cmd
);
   import tsl_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_RM_SUB   = 3'd2;
   localparam logic [2:0] S_RM_SHIFT = 3'd3;
   localparam logic [2:0] S_LOC_SCAN = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE) && !reset;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_APPEND: begin
                  cmd.append = !stat.abort;
                  state_in   = S_DONE;
               end
               OP_REMOVE: begin
                  state_in = stat.abort ? S_DONE : S_RM_SUB;
               end
               OP_LOCATE: begin
                  state_in = S_LOC_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RM_SUB: begin
            cmd.rm_sub = 1'b1;
            state_in   = S_RM_SHIFT;
         end
         S_RM_SHIFT: begin
            // Each entry above the removed one moves down by one place.
            if (stat.rd_in_range) begin
               cmd.rm_shift = 1'b1;
            end else begin
               cmd.rm_finish = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_LOC_SCAN: begin
            if (!stat.rd_in_range) begin
               state_in = S_DONE;
            end else begin
               cmd.loc_step = 1'b1;
               if (stat.loc_stop) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/tsl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeline segment locator datapath
// Segment store, running total, scan pointer and the result register.
// ----------------------------------------------------------------------------
module tsl_dp #(
   parameter int MAX_SEGMENTS = tsl_pkg::MAX_SEGMENTS_DEF,
   parameter int FRAME_BITS   = tsl_pkg::FRAME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tsl_pkg::tsl_cmd_type           cmd,
   output tsl_pkg::tsl_stat_type          stat,
   input  logic [tsl_pkg::OP_W-1:0]       operation,
   input  logic [tsl_pkg::FIELD_W-1:0]    gap_frames,
   input  logic [tsl_pkg::FIELD_W-1:0]    clip_frames,
   input  logic [tsl_pkg::INDEX_W-1:0]    entry_index,
   input  logic [tsl_pkg::POS_W-1:0]      position,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tsl_pkg::STATUS_W-1:0]   status,
   output logic                           in_clip,
   output logic [tsl_pkg::INDEX_W-1:0]    hit_index,
   output logic [tsl_pkg::LOCAL_W-1:0]    local_frame,
   output logic [tsl_pkg::TOTAL_W-1:0]    total_length
);
   import tsl_pkg::*;

   localparam int IDX_W   = $clog2(MAX_SEGMENTS);
   localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int PTR_W   = $clog2(MAX_SEGMENTS + 2);
   localparam int SUM_W   = FRAME_BITS + 1 + $clog2(MAX_SEGMENTS);
   localparam int CMP_W   = (PTR_W > INDEX_W) ? PTR_W : INDEX_W;
   localparam int ENTRY_W = 2 * FRAME_BITS;

   logic [ENTRY_W-1:0]    mem [MAX_SEGMENTS];

   logic [OP_W-1:0]       op_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [CNT_W-1:0]      count_ff;
   logic [PTR_W-1:0]      ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [POS_W-1:0]      rem_ff;
   logic                  hit_ff;
   logic [INDEX_W-1:0]    which_ff;
   logic [LOCAL_W-1:0]    local_ff;
   logic [FRAME_BITS-1:0] gap_ff;
   logic [FRAME_BITS-1:0] len_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_in_clip_ff;
   logic [INDEX_W-1:0]    rsp_hit_ff;
   logic [LOCAL_W-1:0]    rsp_local_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   logic [FRAME_BITS-1:0] rd_gap;
   logic [FRAME_BITS-1:0] rd_len;
   logic                  table_full;
   logic                  index_bad;
   logic                  rem_in_gap;
   logic [POS_W-1:0]      clip_offset;
   logic                  offset_in_clip;
   logic [IDX_W-1:0]      wr_idx;
   logic [TOTAL_W-1:0]    total_sat;

   assign rd_gap = rd_data_ff[ENTRY_W-1:FRAME_BITS];
   assign rd_len = rd_data_ff[FRAME_BITS-1:0];

   assign table_full = (count_ff == CNT_W'(MAX_SEGMENTS));
   assign index_bad  = (CMP_W'(entry_index) >= CMP_W'(count_ff));

   // The remaining distance from the current segment base never goes negative,
   // since the walk stops as soon as the position falls inside a segment.
   assign rem_in_gap     = (rem_ff < POS_W'(rd_gap));
   assign clip_offset    = rem_ff - POS_W'(rd_gap);
   assign offset_in_clip = (clip_offset < POS_W'(rd_len));

   assign wr_idx = IDX_W'(rd_ptr_ff - PTR_W'(1));

   generate
      if (SUM_W > TOTAL_W) begin : g_sat
         assign total_sat = (|sum_ff[SUM_W-1:TOTAL_W]) ? '1 : sum_ff[TOTAL_W-1:0];
      end else begin : g_nosat
         assign total_sat = TOTAL_W'(sum_ff);
      end
   endgenerate

   always_comb begin
      case (operation)
         OP_APPEND: status_in = table_full ? ST_FULL : ST_OK;
         OP_REMOVE: status_in = index_bad ? ST_BAD_INDEX : ST_OK;
         default:   status_in = ST_OK;
      endcase
   end

   assign stat.op          = op_ff;
   assign stat.abort       = (status_ff != ST_OK);
   assign stat.rd_in_range = (rd_ptr_ff < PTR_W'(count_ff));
   assign stat.loc_stop    = rem_in_gap || offset_in_clip;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   // Segment store: at most one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[IDX_W-1:0]] <= {gap_ff, len_ff};
      end else if (cmd.rm_shift) begin
         mem[wr_idx] <= rd_data_ff;
      end
      rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      rd_ptr_ff  <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= operation;
         status_ff <= status_in;
         gap_ff    <= FRAME_BITS'(gap_frames);
         len_ff    <= FRAME_BITS'(clip_frames);
         rem_ff    <= position;
         hit_ff    <= 1'b0;
         which_ff  <= '0;
         local_ff  <= '0;
         ptr_ff    <= (operation == OP_REMOVE) ? PTR_W'(entry_index) : '0;
      end else begin
         ptr_ff <= ptr_ff + PTR_W'(1);
         if (cmd.loc_step) begin
            rem_ff <= clip_offset - POS_W'(rd_len);
            if (!rem_in_gap && offset_in_clip) begin
               hit_ff   <= 1'b1;
               which_ff <= INDEX_W'(rd_ptr_ff);
               local_ff <= LOCAL_W'(clip_offset);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + CNT_W'(1);
         sum_ff   <= sum_ff + SUM_W'(gap_ff) + SUM_W'(len_ff);
      end else if (cmd.rm_sub) begin
         sum_ff <= sum_ff - (SUM_W'(rd_gap) + SUM_W'(rd_len));
      end else if (cmd.rm_finish) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff  <= status_ff;
         rsp_in_clip_ff <= hit_ff;
         rsp_hit_ff     <= which_ff;
         rsp_local_ff   <= local_ff;
         rsp_total_ff   <= total_sat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign status       = rsp_status_ff;
   assign in_clip      = rsp_in_clip_ff;
   assign hit_index    = rsp_hit_ff;
   assign local_frame  = rsp_local_ff;
   assign total_length = rsp_total_ff;

endmodule

@@ rtl/core/timeline_segment_locator.sv @@
`timescale 1ns / 1ps
// One item is in work at a time; the next is taken only after the result of the
// last one has been registered.
// Reset clears the entry count, running total and control; store contents are
// left as they are and never read before being written.
// ----------------------------------------------------------------------------
// Timeline segment locator
// Ordered segment table with append, remove, locate and total operations.
// ----------------------------------------------------------------------------
module timeline_segment_locator #(
   parameter int MAX_SEGMENTS = tsl_pkg::MAX_SEGMENTS_DEF,
   parameter int FRAME_BITS   = tsl_pkg::FRAME_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tsl_req_if.sink   req_ch,
   tsl_rsp_if.source rsp_ch
);
   import tsl_pkg::*;

   tsl_cmd_type  cmd;
   tsl_stat_type stat;

   tsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsl_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .FRAME_BITS   (FRAME_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .operation    (req_ch.operation),
      .gap_frames   (req_ch.gap_frames),
      .clip_frames  (req_ch.clip_frames),
      .entry_index  (req_ch.entry_index),
      .position     (req_ch.position),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .status       (rsp_ch.status),
      .in_clip      (rsp_ch.in_clip),
      .hit_index    (rsp_ch.hit_index),
      .local_frame  (rsp_ch.local_frame),
      .total_length (rsp_ch.total_length)
   );

endmodule

@@ rtl/core/tsl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeline segment locator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "timeline_segment_locator_defines.svh"

module tsl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tsl_pkg::STATUS_W-1:0]   status,
   input logic                           in_clip,
   input logic [tsl_pkg::INDEX_W-1:0]    hit_index,
   input logic [tsl_pkg::LOCAL_W-1:0]    local_frame,
   input logic [tsl_pkg::TOTAL_W-1:0]    total_length
);
   import tsl_pkg::*;

   // Items accepted whose results have not yet been taken.
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 2'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `TSL_ASSERT_RESET(a_rsp_idle_after_reset, clock, reset, !rsp_valid, "result after reset")
   `TSL_ASSERT_IMPL(a_rsp_has_item, clock, reset, rsp_valid, pending_ff != 2'd0, "result without item")
   `TSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `TSL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(status) && $stable(in_clip) && $stable(hit_index) && $stable(local_frame) && $stable(total_length), "result changed while stalled")

endmodule

bind timeline_segment_locator tsl_checker u_tsl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .in_clip      (rsp_ch.in_clip),
   .hit_index    (rsp_ch.hit_index),
   .local_frame  (rsp_ch.local_frame),
   .total_length (rsp_ch.total_length)
);
